/* hw/rtl/assert_macros.svh */
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define LAP_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked out of reset
`define LAP_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/lap_pkg.sv */
`timescale 1ns / 1ps
package lap_pkg;

    localparam int PIX_W        = 8;
    localparam int CFG_W        = 11;
    localparam int CFG_IDX_W    = 2;
    localparam int HEIGHT_LIMIT = 1024;
    localparam int ROW_W        = 10;

    // scaling: ((lap + 288) * 11) / 25, saturated to 0..255
    localparam int BIAS         = 288;
    localparam int SCALE_NUM    = 11;
    localparam int SCALE_DEN    = 25;
    localparam int SAT_LIMIT    = 256 * SCALE_DEN;
    // floor(x / 25) == (x * 5243) >> 17 for every x below SAT_LIMIT
    localparam int RECIP        = 5243;
    localparam int RECIP_SHIFT  = 17;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 2'd0,
        CFG_IMAGE_HEIGHT = 2'd1
    } t_cfg_idx;

    // position flags of one pixel in the frame
    typedef struct packed {
        logic produce;  // interior centre completed by this pixel
        logic last;     // last interior result of the frame
    } t_pos;

endpackage

/* hw/rtl/laplacian_3x3_filter_unit.sv */
`timescale 1ns / 1ps
// a result is registered when its pixel leaves stage a, which holds it under an output stall
// throughput: one pixel per clock unless the output stalls; the line store ram takes one read
// and one write per clock, so nothing in the datapath repeats
// reset (synchronous, active low): width 640, height 480, counts and window cleared,
// pipeline emptied; line store contents are not cleared
module laplacian_3x3_filter_unit
    import lap_pkg::*;
    #(
        parameter int MAX_WIDTH = 1024
    )
    (
        input  logic                 i_clk,
        input  logic                 i_rst_n,
        // pixel input
        input  logic                 i_in_valid,
        output logic                 o_in_stall,
        input  logic [PIX_W-1:0]     i_pixel_in,
        // result output
        output logic                 o_out_valid,
        input  logic                 i_out_stall,
        output logic [PIX_W-1:0]     o_pixel_out,
        output logic                 o_frame_last,
        // register writes
        input  logic                 i_cfg_valid,
        output logic                 o_cfg_ready,
        input  logic [CFG_IDX_W-1:0] i_cfg_index,
        input  logic [CFG_W-1:0]     i_cfg_data
    );

`include "assert_macros.svh"

    localparam int COL_W = $clog2(MAX_WIDTH);

    // pipeline moves whenever the output register is free or being emptied
    logic advance;
    logic in_accept;
    logic b_fire;

    // stage a: accepted pixel while its line store read is in flight
    logic             r_a_valid, n_a_valid;
    logic [PIX_W-1:0] r_a_pixel;
    logic [COL_W-1:0] r_a_col;
    t_pos             r_a_pos;

    // output word
    logic             r_out_valid, n_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_last;

    logic [COL_W-1:0]   scan_col;
    t_pos               scan_pos;
    logic [2*PIX_W-1:0] ram_rd;
    logic [PIX_W-1:0]   kern_result;

    assign advance     = !(r_out_valid && i_out_stall);
    assign o_in_stall  = !advance;
    assign in_accept   = i_in_valid && advance;
    assign b_fire      = r_a_valid && advance;
    assign o_cfg_ready = 1'b1;

    // frame position and size registers
    lap_scan #(
        .MAX_WIDTH (MAX_WIDTH)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_step      (in_accept),
        .o_col       (scan_col),
        .o_pos       (scan_pos)
    );

    // both line stores in one word: upper row in the high byte, lower row in the low byte;
    // consecutive pixels never share a column so the read and the write never collide
    lap_ram #(
        .WIDTH (2 * PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_lines (
        .i_clk     (i_clk),
        .i_wr_en   (b_fire),
        .i_wr_addr (r_a_col),
        .i_wr_data ({ram_rd[PIX_W-1:0], r_a_pixel}),
        .i_rd_en   (in_accept),
        .i_rd_addr (scan_col),
        .o_rd_data (ram_rd)
    );

    // window and arithmetic
    lap_kernel u_kernel (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_shift  (b_fire),
        .i_pixel  (r_a_pixel),
        .i_top    (ram_rd[2*PIX_W-1:PIX_W]),
        .i_mid    (ram_rd[PIX_W-1:0]),
        .o_result (kern_result)
    );

    always_comb begin
        n_a_valid   = advance ? i_in_valid : r_a_valid;
        n_out_valid = advance ? (r_a_valid && r_a_pos.produce) : r_out_valid;
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_a_valid   <= n_a_valid;
            r_out_valid <= n_out_valid;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_a_pixel <= i_pixel_in;
            r_a_col   <= scan_col;
            r_a_pos   <= scan_pos;
        end
        if (b_fire) begin
            r_out_pixel <= kern_result;
            r_out_last  <= r_a_pos.last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_pixel_out  = r_out_pixel;
    assign o_frame_last = r_out_last;

    `LAP_ASSERT_NOW(a_stall_back, i_clk, i_rst_n, r_out_valid && i_out_stall, o_in_stall, "full output did not stall input")
    `LAP_ASSERT_NEXT(a_stage_hold, i_clk, i_rst_n, r_a_valid && !advance, r_a_valid && $stable(r_a_col), "stage a lost its pixel under stall")
    `LAP_ASSERT_NOW(a_interior, i_clk, i_rst_n, r_a_valid && r_a_pos.produce, r_a_col >= COL_W'(2), "result flagged on a border column")

endmodule

/* hw/rtl/lap_ram.sv */
`timescale 1ns / 1ps
module lap_ram
    #(
        parameter int WIDTH = 16,
        parameter int DEPTH = 1024
    )
    (
        input  logic                     i_clk,
        input  logic                     i_wr_en,
        input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
        input  logic [WIDTH-1:0]         i_wr_data,
        input  logic                     i_rd_en,
        input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
        output logic [WIDTH-1:0]         o_rd_data
    );

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

/* hw/rtl/lap_scan.sv */
`timescale 1ns / 1ps
module lap_scan
    import lap_pkg::*;
    #(
        parameter int MAX_WIDTH = 1024
    )
    (
        input  logic                          i_clk,
        input  logic                          i_rst_n,
        input  logic                          i_cfg_valid,
        input  logic [CFG_IDX_W-1:0]          i_cfg_index,
        input  logic [CFG_W-1:0]              i_cfg_data,
        input  logic                          i_step,
        output logic [$clog2(MAX_WIDTH)-1:0]  o_col,
        output t_pos                          o_pos
    );

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int CMP_W = (COL_W + 1 > CFG_W) ? COL_W + 1 : CFG_W;
    localparam logic [CFG_W-1:0] WIDTH_RESET  = CFG_W'(640);
    localparam logic [CFG_W-1:0] HEIGHT_RESET = CFG_W'(480);

    // clamp a requested size and return its last index
    function automatic logic [CMP_W-1:0] last_of(input logic [CFG_W-1:0] value,
                                                 input int unsigned     hi);
        logic [CMP_W-1:0] v;
        v = CMP_W'(value);
        if (v < CMP_W'(3)) begin
            v = CMP_W'(3);
        end else if (v > CMP_W'(hi)) begin
            v = CMP_W'(hi);
        end
        return v - CMP_W'(1);
    endfunction

    logic [COL_W-1:0] r_width_last,  n_width_last;
    logic [ROW_W-1:0] r_height_last, n_height_last;
    logic [COL_W-1:0] r_col, n_col;
    logic [ROW_W-1:0] r_row, n_row;
    logic             col_end, row_end;

    assign col_end = (r_col == r_width_last);
    assign row_end = (r_row == r_height_last);

    always_comb begin
        n_width_last  = r_width_last;
        n_height_last = r_height_last;
        n_col         = r_col;
        n_row         = r_row;
        if (i_step) begin
            if (col_end) begin
                n_col = '0;
                n_row = row_end ? '0 : r_row + ROW_W'(1);
            end else begin
                n_col = r_col + COL_W'(1);
            end
        end
        if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_IMAGE_WIDTH: begin
                    n_width_last = COL_W'(last_of(i_cfg_data, MAX_WIDTH));
                    n_col        = '0;
                    n_row        = '0;
                end
                CFG_IMAGE_HEIGHT: begin
                    n_height_last = ROW_W'(last_of(i_cfg_data, HEIGHT_LIMIT));
                    n_col         = '0;
                    n_row         = '0;
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_last  <= COL_W'(last_of(WIDTH_RESET, MAX_WIDTH));
            r_height_last <= ROW_W'(last_of(HEIGHT_RESET, HEIGHT_LIMIT));
            r_col         <= '0;
            r_row         <= '0;
        end else begin
            r_width_last  <= n_width_last;
            r_height_last <= n_height_last;
            r_col         <= n_col;
            r_row         <= n_row;
        end
    end

    assign o_col         = r_col;
    assign o_pos.produce = (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
    assign o_pos.last    = row_end && col_end;

endmodule

/* hw/rtl/lap_kernel.sv */
`timescale 1ns / 1ps
module lap_kernel
    import lap_pkg::*;
    (
        input  logic             i_clk,
        input  logic             i_rst_n,
        input  logic             i_shift,
        input  logic [PIX_W-1:0] i_pixel,
        input  logic [PIX_W-1:0] i_top,
        input  logic [PIX_W-1:0] i_mid,
        output logic [PIX_W-1:0] o_result
    );

    // centre column of the window plus the west neighbour of the centre
    logic [PIX_W-1:0] r_top, r_bot, r_mid1, r_mid2;

    logic [PIX_W+1:0]   nbr_sum;
    logic signed [11:0] lap;
    logic signed [11:0] biased;
    logic [13:0]        scaled;
    logic [26:0]        prod;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_top  <= '0;
            r_bot  <= '0;
            r_mid1 <= '0;
            r_mid2 <= '0;
        end else if (i_shift) begin
            r_top  <= i_top;
            r_bot  <= i_pixel;
            r_mid1 <= r_mid2;
            r_mid2 <= i_mid;
        end
    end

    // north + south + west + east - 4 * centre
    assign nbr_sum = (PIX_W+2)'(r_top) + (PIX_W+2)'(r_bot)
                   + (PIX_W+2)'(r_mid1) + (PIX_W+2)'(i_mid);
    assign lap     = signed'(12'(nbr_sum)) - signed'(12'({r_mid2, 2'b00}));
    assign biased  = lap + 12'(BIAS);
    assign scaled  = ({3'b000, biased[10:0]} << 3) + ({3'b000, biased[10:0]} << 1)
                   + {3'b000, biased[10:0]};
    assign prod    = 27'(scaled) * 27'(RECIP);

    always_comb begin
        if (biased <= 12'sd0) begin
            o_result = '0;
        end else if (scaled >= 14'(SAT_LIMIT)) begin
            o_result = '1;
        end else begin
            o_result = prod[RECIP_SHIFT +: PIX_W];
        end
    end

endmodule

/* bench/tb_laplacian_3x3_filter_unit.sv */
`timescale 1ns / 1ps
module tb_laplacian_3x3_filter_unit;
    import lap_pkg::*;

    localparam int LINE_MAX      = 1024;
    localparam int CLK_HALF      = 4;
    localparam int RESET_CYCLES  = 2;
    // results are registered as pixels leave stage a; this margin drains the pipeline
    localparam int SETTLE_CYCLES = 4;
    localparam int RANDOM_WORDS  = 940;
    // tail of the random part with no gaps and no stalls
    localparam int QUIET_WORDS   = 150;
    // words sent into each frame opened with an all-ones size
    localparam int CLAMP_WORDS   = 40;
    localparam int CYCLE_LIMIT   = 500000;
    localparam int BURST_MAX     = 7;

    localparam logic [CFG_W-1:0] RESET_WIDTH  = 11'd640;
    localparam logic [CFG_W-1:0] RESET_HEIGHT = 11'd480;
    localparam logic [CFG_W-1:0] CFG_DATA_MAX = '1;

    // index codes past the register list, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_3 = 2'd3;

    typedef struct packed {
        logic [PIX_W-1:0] grey;
        logic             last;
    } t_lap_result;

    // one directed word; want is used only where typed is set
    typedef struct packed {
        logic [PIX_W-1:0] grey;
        logic             typed;
        t_lap_result      want;
    } t_drive_row;

    localparam t_lap_result NO_RESULT = '0;

    logic                 i_clk        = 1'b0;
    logic                 i_rst_n      = 1'b0;
    logic                 i_in_valid   = 1'b0;
    logic                 o_in_stall;
    logic [PIX_W-1:0]     i_pixel_in   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall  = 1'b0;
    logic [PIX_W-1:0]     o_pixel_out;
    logic                 o_frame_last;
    logic                 i_cfg_valid  = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index  = '0;
    logic [CFG_W-1:0]     i_cfg_data   = '0;

    laplacian_3x3_filter_unit #(
        .MAX_WIDTH (LINE_MAX)
    ) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_stall   (o_in_stall),
        .i_pixel_in   (i_pixel_in),
        .o_out_valid  (o_out_valid),
        .i_out_stall  (i_out_stall),
        .o_pixel_out  (o_pixel_out),
        .o_frame_last (o_frame_last),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data)
    );

    always #CLK_HALF i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // filter model state: two line stores, 3x3 neighbourhood, raster position
    // ------------------------------------------------------------------
    logic [PIX_W-1:0] row_above [LINE_MAX];   // pixels two rows up
    logic [PIX_W-1:0] row_prev  [LINE_MAX];   // pixels one row up
    logic [PIX_W-1:0] hood      [3][3];       // [row][column], column 2 newest
    int unsigned      col_at;
    int unsigned      row_at;
    logic [CFG_W-1:0] width_reg;
    logic [CFG_W-1:0] height_reg;

    t_lap_result      pending_laplacians [$];
    t_drive_row       directed_rows [27];
    int               mismatches  = 0;
    int               cycle_count = 0;
    // 1-in-n odds of starting an idle burst on either side, 0 for none
    int unsigned      gap_odds    = 0;
    int unsigned      stall_left  = 0;

    // out-of-range sizes fall back to the nearest legal one
    function automatic int unsigned clamp_size(input logic [CFG_W-1:0] v,
                                               input int unsigned hi);
        if (v < 3)
            return 3;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // advance the model by one pixel; returns 1 when an interior centre completes
    function automatic bit laplace_step(input logic [PIX_W-1:0] grey,
                                        output t_lap_result res);
        int unsigned      w;
        int unsigned      h;
        logic [PIX_W-1:0] up;
        logic [PIX_W-1:0] mid;
        int               lap;
        int               biased;
        int               scaled;
        bit               hit;
        w   = clamp_size(width_reg, LINE_MAX);
        h   = clamp_size(height_reg, HEIGHT_LIMIT);
        up  = row_above[col_at];
        mid = row_prev[col_at];
        row_above[col_at] = mid;
        row_prev[col_at]  = grey;
        for (int k = 0; k < 3; k++) begin
            hood[k][0] = hood[k][1];
            hood[k][1] = hood[k][2];
        end
        hood[0][2] = up;
        hood[1][2] = mid;
        hood[2][2] = grey;
        hit = (row_at >= 2) && (col_at >= 2);
        res = NO_RESULT;
        if (hit) begin
            // north + south + west + east - 4 * centre
            lap = int'(hood[0][1]) + int'(hood[2][1]) + int'(hood[1][0])
                + int'(hood[1][2]) - 4 * int'(hood[1][1]);
            biased = lap + BIAS;
            scaled = (biased <= 0) ? 0 : (biased * SCALE_NUM) / SCALE_DEN;
            res.grey = (scaled > 255) ? '1 : PIX_W'(scaled);
            res.last = (row_at + 1 >= h) && (col_at + 1 >= w);
        end
        if (col_at + 1 >= w) begin
            col_at = 0;
            row_at = (row_at + 1 >= h) ? 0 : row_at + 1;
        end else begin
            col_at++;
        end
        return hit;
    endfunction

    function automatic logic [PIX_W-1:0] random_grey();
        case ($urandom_range(0, 7))
            0: begin
                return '0;
            end
            1: begin
                return '1;
            end
            default: begin
                return PIX_W'($urandom_range(0, 255));
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // drivers: entered and left at a falling edge with nothing yet driven
    // ------------------------------------------------------------------
    task automatic feed_pixel(input logic [PIX_W-1:0] grey, input bit typed,
                              input t_lap_result want);
        t_lap_result res;
        if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, BURST_MAX)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_pixel_in <= grey;
        do @(posedge i_clk); while (o_in_stall);
        // word taken on this edge
        if (laplace_step(grey, res))
            pending_laplacians.push_back(typed ? want : res);
        @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        // only the two listed registers take effect, and each restarts the frame
        if (idx == CFG_IMAGE_WIDTH || idx == CFG_IMAGE_HEIGHT) begin
            if (idx == CFG_IMAGE_WIDTH)
                width_reg = data;
            else
                height_reg = data;
            col_at = 0;
            row_at = 0;
        end
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
        @(negedge i_clk);
    endtask

    // let every owed result drain, then the pipeline, before touching registers
    task automatic settle();
        i_in_valid <= 1'b0;
        while (pending_laplacians.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // output side back-pressure in random bursts
    always @(negedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  = stall_left - 1;
            i_out_stall <= 1'b1;
        end else if (gap_odds != 0 && $urandom_range(1, gap_odds) == 1) begin
            stall_left  = $urandom_range(0, BURST_MAX - 1);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // every result word taken is matched against the oldest owed one
    always @(posedge i_clk) begin : result_check
        t_lap_result owed;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_laplacians.size() == 0) begin
                $display("%0t: result with none owed, pixel_out %0d frame_last %0b",
                         $time, o_pixel_out, o_frame_last);
                mismatches++;
            end else begin
                owed = pending_laplacians.pop_front();
                if (o_pixel_out !== owed.grey) begin
                    $display("%0t: pixel_out expected %0d got %0d",
                             $time, owed.grey, o_pixel_out);
                    mismatches++;
                end
                if (o_frame_last !== owed.last) begin
                    $display("%0t: frame_last expected %0b got %0b",
                             $time, owed.last, o_frame_last);
                    mismatches++;
                end
            end
        end
    end

    // run limit, far above the slowest legal run
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_laplacian_3x3_filter_unit NOT OK");
            $finish;
        end
    end

    initial begin
        int          random_words;
        int          span;
        int unsigned pick;
        logic [CFG_W-1:0] new_width;
        logic [CFG_W-1:0] new_height;

        random_words = 0;
        width_reg    = RESET_WIDTH;
        height_reg   = RESET_HEIGHT;
        col_at       = 0;
        row_at       = 0;
        foreach (row_above[n]) begin
            row_above[n] = '0;
            row_prev[n]  = '0;
        end
        foreach (hood[r, c])
            hood[r][c] = '0;

        // three 3x3 frames back to back, so each also checks the wrap to a new frame
        directed_rows = '{
            // flat frame: only the bias survives, 288 * 11 / 25 truncates to 126
            '{8'd0,   1'b0, NO_RESULT}, '{8'd0, 1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT},
            '{8'd0,   1'b0, NO_RESULT}, '{8'd0, 1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT},
            '{8'd0,   1'b0, NO_RESULT}, '{8'd0, 1'b0, NO_RESULT}, '{8'd0,   1'b1, '{8'd126, 1'b1}},
            // bright centre on black: most negative laplacian, clipped to 0
            '{8'd0,   1'b0, NO_RESULT}, '{8'd0, 1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT},
            '{8'd0,   1'b0, NO_RESULT}, '{8'd255, 1'b0, NO_RESULT}, '{8'd0, 1'b0, NO_RESULT},
            '{8'd0,   1'b0, NO_RESULT}, '{8'd0, 1'b0, NO_RESULT}, '{8'd0,   1'b1, '{8'd0, 1'b1}},
            // dark centre in white: most positive laplacian, clipped to 255
            '{8'd255, 1'b0, NO_RESULT}, '{8'd255, 1'b0, NO_RESULT}, '{8'd255, 1'b0, NO_RESULT},
            '{8'd255, 1'b0, NO_RESULT}, '{8'd0,   1'b0, NO_RESULT}, '{8'd255, 1'b0, NO_RESULT},
            '{8'd255, 1'b0, NO_RESULT}, '{8'd255, 1'b0, NO_RESULT}, '{8'd255, 1'b1, '{8'd255, 1'b1}}
        };

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n  <= 1'b1;
        gap_odds = 6;
        @(negedge i_clk);

        // reset sizes: the first words sit in row 0 and owe nothing
        repeat (3) feed_pixel(random_grey(), 1'b0, NO_RESULT);

        // sizes below the floor clamp to a 3x3 frame
        settle();
        write_reg(CFG_IMAGE_WIDTH, '0);
        write_reg(CFG_IMAGE_HEIGHT, 11'd2);
        foreach (directed_rows[n])
            feed_pixel(directed_rows[n].grey, directed_rows[n].typed, directed_rows[n].want);

        // all-ones width clamps to the line store depth: the opening words stay in row 0
        settle();
        write_reg(CFG_IMAGE_WIDTH, CFG_DATA_MAX);
        write_reg(CFG_IMAGE_HEIGHT, 11'd3);
        repeat (CLAMP_WORDS) feed_pixel(random_grey(), 1'b0, NO_RESULT);

        // all-ones height clamps to the row limit: no frame end within the opening rows
        settle();
        write_reg(CFG_IMAGE_WIDTH, 11'd3);
        write_reg(CFG_IMAGE_HEIGHT, CFG_DATA_MAX);
        repeat (CLAMP_WORDS) feed_pixel(random_grey(), 1'b0, NO_RESULT);

        // back to small frames before the random part
        settle();
        write_reg(CFG_IMAGE_WIDTH, 11'd5);
        write_reg(CFG_IMAGE_HEIGHT, 11'd4);

        // random phases: small frames, often cut short by a size write mid-frame
        while (random_words < RANDOM_WORDS) begin
            if (random_words >= RANDOM_WORDS - QUIET_WORDS) begin
                gap_odds = 0;
            end else begin
                case ($urandom_range(0, 2))
                    0: begin
                        gap_odds = 0;
                    end
                    1: begin
                        gap_odds = 3;
                    end
                    default: begin
                        gap_odds = 8;
                    end
                endcase
            end
            settle();

            case ($urandom_range(0, 9))
                0: begin
                    new_width = CFG_W'($urandom_range(0, 2));
                end
                1: begin
                    new_width = CFG_W'($urandom_range(9, 32));
                end
                default: begin
                    new_width = CFG_W'($urandom_range(3, 8));
                end
            endcase
            case ($urandom_range(0, 9))
                0: begin
                    new_height = CFG_W'($urandom_range(0, 2));
                end
                1: begin
                    new_height = CFG_W'($urandom_range(7, 12));
                end
                default: begin
                    new_height = CFG_W'($urandom_range(3, 6));
                end
            endcase

            // some phases carry on the frame left open by the last one
            pick = $urandom_range(0, 9);
            if (pick <= 5)
                write_reg(CFG_IMAGE_WIDTH, new_width);
            if (pick <= 3 || pick == 6)
                write_reg(CFG_IMAGE_HEIGHT, new_height);
            if (pick == 7)
                write_reg($urandom_range(0, 1) ? CFG_SPARE_2 : CFG_SPARE_3, CFG_W'($urandom));

            span = $urandom_range(1, 2 * clamp_size(width_reg, LINE_MAX)
                                        * clamp_size(height_reg, HEIGHT_LIMIT));
            // never run past the word budget
            if (span > RANDOM_WORDS - random_words)
                span = RANDOM_WORDS - random_words;
            repeat (span) begin
                feed_pixel(random_grey(), 1'b0, NO_RESULT);
                random_words++;
            end
        end

        gap_odds = 0;
        settle();
        if (mismatches == 0)
            $display("tb_laplacian_3x3_filter_unit OK");
        else
            $display("tb_laplacian_3x3_filter_unit NOT OK");
        $finish;
    end

endmodule

/* laplacian_3x3_filter_unit.f */
+incdir+hw/rtl
hw/rtl/lap_pkg.sv
hw/rtl/lap_ram.sv
hw/rtl/lap_scan.sv
hw/rtl/lap_kernel.sv
hw/rtl/laplacian_3x3_filter_unit.sv
bench/tb_laplacian_3x3_filter_unit.sv
